[sv/fft_pkg.sv]
package fft_pkg;

    localparam int MAX_LOG2_DEF      = 6;
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int TWIDDLE_WIDTH_DEF = 16;
    localparam int BIN_INDEX_WIDTH   = 6;
    localparam int LOG2_CFG_WIDTH    = 3;
    localparam int CFG_INDEX_WIDTH   = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERSE_MODE = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOG2_POINTS  = 1'd1;

    localparam logic [LOG2_CFG_WIDTH-1:0] LOG2_RESET = 3'd6;

    // Angle scale: 2*pi in Q30.
    localparam longint TWO_PI_Q30 = 64'sd6746518852;

    // Command word from the controller to the datapath.
    typedef struct packed {
        logic        load_wr;      // write an input sample
        logic        bf_rd;        // read a butterfly pair
        logic        bf_wr;        // write a butterfly result
        logic        out_rd;       // read a bin for output
        logic        out_wr;       // present the read bin on the output
        logic        j_zero;       // butterfly twiddle index is zero
        logic        inv;          // inverse transform
        logic        last;         // final bin
        logic        clr_sat;      // clear saturation flag
    } fft_cmd_t;

    // Truncated Taylor series, Q30, for 0 <= x <= pi/4.
    // Terms stay non-negative, so each step divides by a fixed factorial ratio.
    function automatic longint series(input longint x, input bit want_sin);
        longint x2;
        longint term;
        longint sum;
        x2 = (x * x) >>> 30;
        term = want_sin ? x : (64'sd1 <<< 30);
        sum = term;
        for (int i = 1; i <= 6; i++) begin
            term = (term * x2) >>> 30;
            case (i)
                1: term = want_sin ? term / 6   : term / 2;
                2: term = want_sin ? term / 20  : term / 12;
                3: term = want_sin ? term / 42  : term / 30;
                4: term = want_sin ? term / 72  : term / 56;
                5: term = want_sin ? term / 110 : term / 90;
                6: term = want_sin ? term / 156 : term / 132;
                default: ;
            endcase
            sum = ((i & 1) != 0) ? sum - term : sum + term;
        end
        if (sum < 0) sum = 0;
        return sum;
    endfunction

    function automatic longint to_rom(input longint q30, input int frac);
        longint v;
        longint mx;
        v = (q30 + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
        mx = (64'sd1 <<< frac) - 1;
        return (v > mx) ? mx : v;
    endfunction

    // cos (want_sin = 0) or sin of 2*pi*k/2^lg_nm in Q1.frac
    function automatic longint twiddle(input longint k, input int lg_nm, input int frac,
                                       input bit want_sin);
        longint nm;
        longint q;
        bit     quad;
        longint cq;
        longint sq;
        longint x;
        nm = 64'sd1 <<< lg_nm;
        q = k;
        quad = 1'b0;
        if (4 * q > nm) begin
            q = q - (nm >>> 2);
            quad = 1'b1;
        end
        if (8 * q <= nm) begin
            x = (TWO_PI_Q30 * q) >>> lg_nm;
            cq = to_rom(series(x, 1'b0), frac);
            sq = to_rom(series(x, 1'b1), frac);
        end else begin
            x = (TWO_PI_Q30 * ((nm >>> 2) - q)) >>> lg_nm;
            cq = to_rom(series(x, 1'b1), frac);
            sq = to_rom(series(x, 1'b0), frac);
        end
        if (quad) return want_sin ? cq : -sq;
        return want_sin ? sq : cq;
    endfunction

endpackage

[sv/fft_ram.sv]
module fft_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/fft_ctrl.sv]
module fft_ctrl #(
    parameter int MAX_LOG2 = fft_pkg::MAX_LOG2_DEF,
    localparam int AW = MAX_LOG2,
    localparam int LW = $clog2(MAX_LOG2 + 1),
    localparam int BIN_W = fft_pkg::BIN_INDEX_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               cfg_inv,
    input  logic [fft_pkg::LOG2_CFG_WIDTH-1:0] cfg_log2,
    input  logic                               out_busy,   // output slot full, not taken
    output fft_pkg::fft_cmd_t                  cmd,
    output logic [AW-1:0]                      addr_a,
    output logic [AW-1:0]                      addr_b,
    output logic [AW-1:0]                      tw_idx,
    output logic [LW-1:0]                      shift_lg,
    output logic [BIN_W-1:0]                   bin_idx
);

    typedef enum logic [2:0] {LOAD, BF_A, BF_B, BF_W1, BF_W2, OUT_RD, OUT_WAIT} state_t;

    state_t          state_reg;
    logic [AW:0]     cnt_reg;      // load count / bin counter
    logic [LW-1:0]   lg_reg;
    logic [LW-1:0]   st_reg;       // stage
    logic [AW-1:0]   j_reg;
    logic [AW-1:0]   i_reg;
    logic            inv_reg;
    logic            seen_reg;     // first sample of load taken

    logic [LW-1:0]   lg_eff;
    logic [AW:0]     n_eff;
    logic [AW-1:0]   le;
    logic [AW-1:0]   slot;
    logic [AW:0]     i_nxt;
    logic [AW:0]     j_nxt;
    logic [AW-1:0]   rev;
    logic            s_fire;

    always_comb begin
        if (cfg_log2 == '0) lg_eff = LW'(1);
        else if (32'(cfg_log2) > MAX_LOG2) lg_eff = LW'(MAX_LOG2);
        else lg_eff = LW'(cfg_log2);
    end

    assign n_eff  = (AW+1)'(1) << lg_eff;
    assign le     = AW'(((AW+1)'(1) << lg_reg) >> (st_reg + LW'(1)));
    assign slot   = cnt_reg[AW-1:0];
    assign s_ready = (state_reg == LOAD);
    assign s_fire  = s_valid && s_ready;
    assign i_nxt   = (AW+1)'(i_reg) + (AW+1)'({le, 1'b0});
    assign j_nxt   = (AW+1)'(j_reg) + (AW+1)'(1);

    always_comb begin
        rev = '0;
        for (int b = 0; b < AW; b++) begin
            if (LW'(b) < lg_reg) rev[32'(lg_reg) - 1 - b] = cnt_reg[b];
        end
    end

    always_comb begin
        cmd = '0;
        cmd.inv     = inv_reg;
        cmd.j_zero  = (j_reg == '0);
        cmd.load_wr = s_fire;
        cmd.clr_sat = s_fire && !seen_reg;
        cmd.bf_rd   = (state_reg == BF_A);
        cmd.bf_wr   = (state_reg == BF_W2);
        cmd.out_rd  = (state_reg == OUT_RD);
        cmd.out_wr  = (state_reg == OUT_WAIT) && !out_busy;
        cmd.last    = (cnt_reg[AW-1:0] == AW'(((AW+1)'(1) << lg_reg) - 1)) ;
        addr_a = (state_reg == LOAD) ? slot : i_reg;
        addr_b = (state_reg == OUT_RD || state_reg == OUT_WAIT) ? rev : i_reg + le;
        tw_idx = AW'(j_reg << (AW'(MAX_LOG2) - AW'(lg_reg) + AW'(st_reg)));
        shift_lg = lg_reg;
        bin_idx = BIN_W'(cnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LOAD;
            cnt_reg   <= '0;
            lg_reg    <= LW'(1);
            st_reg    <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            inv_reg   <= 1'b0;
            seen_reg  <= 1'b0;
        end else begin
            case (state_reg)
                LOAD: begin
                    if (s_fire) begin
                        seen_reg <= 1'b1;
                        if ((AW+1)'(slot) + (AW+1)'(1) >= n_eff) begin
                            state_reg <= BF_A;
                            lg_reg    <= lg_eff;
                            inv_reg   <= cfg_inv;
                            st_reg    <= '0;
                            j_reg     <= '0;
                            i_reg     <= '0;
                            cnt_reg   <= '0;
                        end else begin
                            cnt_reg <= (AW+1)'(slot) + (AW+1)'(1);
                        end
                    end
                end
                BF_A:  state_reg <= BF_B;
                BF_B:  state_reg <= BF_W1;
                BF_W1: state_reg <= BF_W2;
                BF_W2: begin
                    if (i_nxt < ((AW+1)'(1) << lg_reg)) begin
                        i_reg <= i_nxt[AW-1:0];
                        state_reg <= BF_A;
                    end else if (j_nxt < (AW+1)'(le)) begin
                        j_reg <= j_nxt[AW-1:0];
                        i_reg <= j_nxt[AW-1:0];
                        state_reg <= BF_A;
                    end else if (st_reg + LW'(1) < lg_reg) begin
                        st_reg <= st_reg + LW'(1);
                        j_reg <= '0;
                        i_reg <= '0;
                        state_reg <= BF_A;
                    end else begin
                        state_reg <= OUT_RD;
                    end
                end
                OUT_RD: state_reg <= OUT_WAIT;
                OUT_WAIT: begin
                    if (!out_busy) begin
                        if (cmd.last) begin
                            state_reg <= LOAD;
                            cnt_reg   <= '0;
                            seen_reg  <= 1'b0;
                        end else begin
                            cnt_reg   <= cnt_reg + (AW+1)'(1);
                            state_reg <= OUT_RD;
                        end
                    end
                end
                default: state_reg <= LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != LOAD) |-> !s_ready) else $error("ready outside load");
    a_lg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (lg_reg >= LW'(1)) && (32'(lg_reg) <= MAX_LOG2)) else $error("bad length");
    a_st_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != LOAD) |-> (st_reg < lg_reg)) else $error("stage overrun");
`endif

endmodule

[sv/fft_dp.sv]
module fft_dp #(
    parameter int MAX_LOG2      = fft_pkg::MAX_LOG2_DEF,
    parameter int SAMPLE_WIDTH  = fft_pkg::SAMPLE_WIDTH_DEF,
    parameter int TWIDDLE_WIDTH = fft_pkg::TWIDDLE_WIDTH_DEF,
    localparam int AW = MAX_LOG2,
    localparam int LW = $clog2(MAX_LOG2 + 1),
    localparam int BW = SAMPLE_WIDTH + MAX_LOG2 + 1,
    localparam int TW = TWIDDLE_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fft_pkg::fft_cmd_t                  cmd,
    input  logic [AW-1:0]                      addr_a,
    input  logic [AW-1:0]                      addr_b,
    input  logic [AW-1:0]                      tw_idx,
    input  logic [LW-1:0]                      shift_lg,
    input  logic [fft_pkg::BIN_INDEX_WIDTH-1:0] bin_idx,
    input  logic signed [SAMPLE_WIDTH-1:0]     s_re,
    input  logic signed [SAMPLE_WIDTH-1:0]     s_im,
    output logic                               out_busy,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [BW-1:0]               m_re,
    output logic signed [BW-1:0]               m_im,
    output logic [fft_pkg::BIN_INDEX_WIDTH-1:0] m_idx,
    output logic                               m_last,
    output logic                               m_ovf
);
    localparam int NPTS = 1 << MAX_LOG2;
    localparam int HALF = NPTS / 2;
    localparam int FR   = TW - 1;
    localparam int DW   = BW + 1;
    localparam int PW   = DW + TW;

    typedef logic signed [TW-1:0] tw_t;

    // Twiddle ROM: constant cos/sin table over the first half circle.
    tw_t cos_tab [HALF];
    tw_t sin_tab [HALF];
    for (genvar g = 0; g < HALF; g++) begin : g_tw
        localparam longint COS_V = fft_pkg::twiddle(longint'(g), MAX_LOG2, FR, 1'b0);
        localparam longint SIN_V = fft_pkg::twiddle(longint'(g), MAX_LOG2, FR, 1'b1);
        assign cos_tab[g] = tw_t'(COS_V);
        assign sin_tab[g] = tw_t'(SIN_V);
    end

    // Two RAMs per component: port A and port B read copies.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [BW-1:0] wr_re, wr_im;
    logic [BW-1:0] ra_re, ra_im, rb_re, rb_im;
    logic [AW-1:0] rd_a;

    // pipeline
    logic signed [DW-1:0] sum_re_reg, sum_im_reg, dr_reg, di_reg;
    logic signed [TW-1:0] wr_reg, wi_reg;
    logic                 jz_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [AW-1:0]        a_reg, b_reg;
    logic                 phase_reg;    // 0: write upper, 1: write lower
    logic                 sat_reg;
    logic                 sat_hit;
    logic signed [BW-1:0] lo_re, lo_im, up_re, up_im;
    logic signed [PW:0]   mr, mi;
    logic signed [BW:0]   rr, ri;

    fft_ram #(.WIDTH(BW), .DEPTH(NPTS)) u_ra_re (.aclk, .wr_en, .wr_addr, .wr_data(wr_re),
        .rd_addr(rd_a), .rd_data(ra_re));
    fft_ram #(.WIDTH(BW), .DEPTH(NPTS)) u_ra_im (.aclk, .wr_en, .wr_addr, .wr_data(wr_im),
        .rd_addr(rd_a), .rd_data(ra_im));
    fft_ram #(.WIDTH(BW), .DEPTH(NPTS)) u_rb_re (.aclk, .wr_en, .wr_addr, .wr_data(wr_re),
        .rd_addr(addr_b), .rd_data(rb_re));
    fft_ram #(.WIDTH(BW), .DEPTH(NPTS)) u_rb_im (.aclk, .wr_en, .wr_addr, .wr_data(wr_im),
        .rd_addr(addr_b), .rd_data(rb_im));

    assign rd_a = addr_a;

    function automatic logic signed [BW-1:0] sat(input logic signed [PW:0] v);
        logic signed [PW:0] hi;
        logic signed [PW:0] lo;
        hi = (PW+1)'((64'sd1 <<< (BW-1)) - 1);
        lo = -(PW+1)'(64'sd1 <<< (BW-1));
        if (v > hi) return BW'(hi);
        if (v < lo) return BW'(lo);
        return BW'(v);
    endfunction

    // stage 1 (BF_B): RAM data valid, form sum/diff, twiddle.  stage 2 (BF_W1): products.
    // BF_W2: upper writes on BF_W1 cycle, lower on BF_W2.
    logic st1, st2;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1 <= 1'b0;
            st2 <= 1'b0;
        end else begin
            st1 <= cmd.bf_rd;
            st2 <= st1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bf_rd) begin
            a_reg <= addr_a;
            b_reg <= addr_b;
            jz_reg <= cmd.j_zero;
            wr_reg <= cos_tab[tw_idx[AW-2:0]];
            wi_reg <= cmd.inv ? sin_tab[tw_idx[AW-2:0]] : -sin_tab[tw_idx[AW-2:0]];
        end
        if (st1) begin
            sum_re_reg <= DW'($signed(ra_re)) + DW'($signed(rb_re));
            sum_im_reg <= DW'($signed(ra_im)) + DW'($signed(rb_im));
            dr_reg <= DW'($signed(ra_re)) - DW'($signed(rb_re));
            di_reg <= DW'($signed(ra_im)) - DW'($signed(rb_im));
        end
        if (st2) begin
            p1_reg <= PW'(dr_reg * wr_reg);
            p2_reg <= PW'(di_reg * wi_reg);
            p3_reg <= PW'(dr_reg * wi_reg);
            p4_reg <= PW'(di_reg * wr_reg);
        end
    end

    assign up_re = sat((PW+1)'(sum_re_reg));
    assign up_im = sat((PW+1)'(sum_im_reg));
    assign mr = ((PW+1)'(p1_reg) - (PW+1)'(p2_reg) + (PW+1)'(64'sd1 <<< (FR-1))) >>> FR;
    assign mi = ((PW+1)'(p3_reg) + (PW+1)'(p4_reg) + (PW+1)'(64'sd1 <<< (FR-1))) >>> FR;
    assign lo_re = jz_reg ? sat((PW+1)'(dr_reg)) : sat(mr);
    assign lo_im = jz_reg ? sat((PW+1)'(di_reg)) : sat(mi);

    always_comb begin
        wr_en = 1'b0;
        wr_addr = a_reg;
        wr_re = up_re;
        wr_im = up_im;
        sat_hit = 1'b0;
        if (cmd.load_wr) begin
            wr_en = 1'b1;
            wr_addr = addr_a;
            wr_re = BW'(s_re);
            wr_im = BW'(s_im);
        end else if (st2) begin
            wr_en = 1'b1;
            sat_hit = ((PW+1)'(up_re) != (PW+1)'(sum_re_reg)) ||
                      ((PW+1)'(up_im) != (PW+1)'(sum_im_reg));
        end else if (cmd.bf_wr) begin
            wr_en = 1'b1;
            wr_addr = b_reg;
            wr_re = lo_re;
            wr_im = lo_im;
            sat_hit = jz_reg ?
                ((PW+1)'(lo_re) != (PW+1)'(dr_reg)) || ((PW+1)'(lo_im) != (PW+1)'(di_reg)) :
                ((PW+1)'(lo_re) != mr) || ((PW+1)'(lo_im) != mi);
        end
    end

    // Output: bin read from port B, optionally scaled.
    assign rr = ((BW+1)'($signed(rb_re)) + ((BW+1)'(1) <<< (shift_lg - LW'(1)))) >>> shift_lg;
    assign ri = ((BW+1)'($signed(rb_im)) + ((BW+1)'(1) <<< (shift_lg - LW'(1)))) >>> shift_lg;
    assign out_busy = m_valid && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg   <= 1'b0;
            m_valid   <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= st2;
            if (cmd.clr_sat) sat_reg <= 1'b0;
            else if (sat_hit) sat_reg <= 1'b1;
            if (cmd.out_wr) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_wr) begin
            m_re   <= cmd.inv ? BW'(rr) : $signed(rb_re);
            m_im   <= cmd.inv ? BW'(ri) : $signed(rb_im);
            m_idx  <= bin_idx;
            m_last <= cmd.last;
            m_ovf  <= sat_reg;
        end
    end

`ifndef SYNTHESIS
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_wr && (st2 || cmd.bf_wr))) else $error("write clash");
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.bf_wr |-> phase_reg) else $error("lower before upper");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_wr |-> !out_busy) else $error("output overwrite");
`endif

endmodule

[sv/radix2_fft_ifft.sv]
// Radix-2 DIF FFT/IFFT, in place, N = 2^log2_points up to 2^MAX_LOG2.
// Load: one sample word per cycle while in load. Transform: one butterfly at a time on one
// shared unit (read, sum/diff, multiply, write), N/2*log2(N) butterflies in all.
// Input blocked until the last bin has been placed on the output.
// Sync active-low reset: load count, flag, handshakes cleared, config to defaults.
module radix2_fft_ifft #(
    parameter int MAX_LOG2      = fft_pkg::MAX_LOG2_DEF,
    parameter int SAMPLE_WIDTH  = fft_pkg::SAMPLE_WIDTH_DEF,
    parameter int TWIDDLE_WIDTH = fft_pkg::TWIDDLE_WIDTH_DEF,
    localparam int BW = SAMPLE_WIDTH + MAX_LOG2 + 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fft_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [fft_pkg::LOG2_CFG_WIDTH-1:0]    cfg_data,
    // sample input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_sample_imag,
    // bin output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [BW-1:0]                  m_bin_real,
    output logic signed [BW-1:0]                  m_bin_imag,
    output logic [fft_pkg::BIN_INDEX_WIDTH-1:0]   m_bin_index,
    output logic                                  m_last_bin,
    output logic                                  m_overflow_flag
);
    localparam int AW = MAX_LOG2;
    localparam int LW = $clog2(MAX_LOG2 + 1);

    logic                               inv_reg;
    logic [fft_pkg::LOG2_CFG_WIDTH-1:0] log2_reg;
    fft_pkg::fft_cmd_t                  cmd;
    logic [AW-1:0]                      addr_a, addr_b, tw_idx;
    logic [LW-1:0]                      shift_lg;
    logic [fft_pkg::BIN_INDEX_WIDTH-1:0] bin_idx;
    logic                               out_busy;

    // Config: always ready; unknown index ignored by width.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg  <= 1'b0;
            log2_reg <= fft_pkg::LOG2_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                fft_pkg::REG_INVERSE_MODE: inv_reg <= cfg_data[0];
                fft_pkg::REG_LOG2_POINTS:  log2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    fft_ctrl #(.MAX_LOG2(MAX_LOG2)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready,
        .cfg_inv(inv_reg), .cfg_log2(log2_reg), .out_busy,
        .cmd, .addr_a, .addr_b, .tw_idx, .shift_lg, .bin_idx
    );

    fft_dp #(.MAX_LOG2(MAX_LOG2), .SAMPLE_WIDTH(SAMPLE_WIDTH),
             .TWIDDLE_WIDTH(TWIDDLE_WIDTH)) u_dp (
        .aclk, .aresetn, .cmd, .addr_a, .addr_b, .tw_idx, .shift_lg, .bin_idx,
        .s_re(s_sample_real), .s_im(s_sample_imag), .out_busy,
        .m_valid, .m_ready, .m_re(m_bin_real), .m_im(m_bin_imag),
        .m_idx(m_bin_index), .m_last(m_last_bin), .m_ovf(m_overflow_flag)
    );

endmodule
